### hw/rtl/bap_pkg.sv
`default_nettype none

package bap_pkg;

    // result list per transaction
    localparam int MAX_RES     = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
    localparam int NUM_DENOM   = 4;
    localparam int COUNT_OUT_W = 16;

    // frame characters
    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_Q      = "?";
    localparam logic [7:0] CH_UA     = "A";
    localparam logic [7:0] CH_UB     = "B";
    localparam logic [7:0] CH_UC     = "C";
    localparam logic [7:0] CH_UE     = "E";
    localparam logic [7:0] CH_UG     = "G";
    localparam logic [7:0] CH_UK     = "K";
    localparam logic [7:0] CH_UN     = "N";
    localparam logic [7:0] CH_UO     = "O";
    localparam logic [7:0] CH_US     = "S";
    localparam logic [7:0] CH_LA     = "a";
    localparam logic [7:0] CH_LB     = "b";
    localparam logic [7:0] CH_LC     = "c";
    localparam logic [7:0] CH_LE     = "e";
    localparam logic [7:0] CH_LG     = "g";
    localparam logic [7:0] CH_LS     = "s";

    // acceptor status codes
    localparam logic [7:0] ST_RESET     = 8'd0;
    localparam logic [7:0] ST_INIT      = 8'd1;
    localparam logic [7:0] ST_STACKING  = 8'd5;
    localparam logic [7:0] ST_ESCROW    = 8'd11;
    localparam logic [7:0] ST_FAULT     = 8'd12;
    localparam logic [7:0] ST_INHIBITED = 8'd18;

    // set-acceptor arguments
    localparam logic [7:0] ARG_ENABLE = 8'd13;
    localparam logic [7:0] ARG_STACK  = 8'h09;

    // bill codes
    localparam logic [7:0] BILL_1000  = 8'd1;
    localparam logic [7:0] BILL_5000  = 8'd5;
    localparam logic [7:0] BILL_10000 = 8'd10;
    localparam logic [7:0] BILL_50000 = 8'd50;

    // config frame bits
    localparam int CFG_STACK_BIT  = 4;
    localparam int CFG_NOPOLL_BIT = 5;

    // tick limits, 100 ms units
    localparam logic [7:0] TICK_RESEND   = 8'd5;
    localparam logic [7:0] TICK_POLL     = 8'd2;
    localparam logic [7:0] TICK_MIN_WAIT = 8'd12;
    localparam logic [7:0] TICK_MAX_WAIT = 8'd20;

    typedef enum logic [2:0] {
        MODE_BYTE     = 3'd0,
        MODE_TICK     = 3'd1,
        MODE_HOST     = 3'd2,
        MODE_AUTO_ON  = 3'd3,
        MODE_AUTO_OFF = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_10   = 3'd1,
        PH_11   = 3'd2,
        PH_12   = 3'd3,
        PH_13   = 3'd4,
        PH_14   = 3'd5,
        PH_15   = 3'd6,
        PH_16   = 3'd7
    } phase_t;

    typedef enum logic {
        KIND_REPORT = 1'b0,
        KIND_SEND   = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } frame_t;

    typedef struct packed {
        frame_t [MAX_RES-1:0]  f;
        logic [RES_CNT_W-1:0]  n;
    } frame_list_t;

    typedef struct packed {
        frame_list_t                             frames;
        logic [NUM_DENOM-1:0][COUNT_OUT_W-1:0]   counts;
        phase_t                                  phase;
    } step_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] cmd_byte;
        logic [7:0] sub_byte;
        logic [7:0] arg_byte;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] sum_byte;
        logic [15:0] count_1000;
        logic [15:0] count_5000;
        logic [15:0] count_10000;
        logic [15:0] count_50000;
        logic [2:0] auto_state;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/bap_stream_if.sv
`default_nettype none

interface bap_stream_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bill_acceptor_host_protocol.sv
`default_nettype none

// Host-side engine for a banknote acceptor on a five-byte framed link ('$', three
// payload bytes, 8-bit sum). Each item transaction is a received byte, a 100 ms tick,
// a host command frame, or an auto on/off request. A received valid frame yields a
// report result (kind 0); every frame to transmit yields a send result (kind 1).
// One item causes zero to five results, delivered in order one per cycle while the
// receiver is ready; every result of an item carries the bill counters and sequencer
// phase as they stand after that item, and last marks its final result. The item is
// decoded and the whole state updated in the cycle it is accepted, and its results
// are loaded into a five-entry result list. An item that causes at most one result
// is taken every cycle while the receiver is ready; otherwise the next item is taken
// in the cycle the last result of the list leaves, so the list drain sets the rate.
// The first result is offered in the cycle after acceptance. COUNT_WIDTH sets the
// internal width of the bill counters (they saturate at all ones); the reported
// counts are their low 16 bits.
module bill_acceptor_host_protocol
    import bap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    bap_stream_if.sink   item,
    bap_stream_if.source result
);

    logic  accept;
    logic  can_load;
    step_t step;

    // an item transaction is taken when the result list is free or about to be
    assign item.ready = can_load;
    assign accept     = item.valid && item.ready;

    // frame window, sequencer state and bill counters
    bap_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .step_item (item.data),
        .step_res  (step)
    );

    // result list, drained one result transaction per cycle while the receiver is ready
    bap_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .step     (step),
        .can_load (can_load),
        .result   (result)
    );

endmodule

`default_nettype wire

### hw/rtl/bap_core.sv
`default_nettype none

module bap_core
    import bap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step_en,
    input  item_t step_item,
    output step_t step_res
);

    logic [3:0][7:0]                       win_reg, win_next;
    logic                                  auto_reg, auto_next;
    phase_t                                phase_reg, phase_next;
    logic [7:0]                            tick_reg, tick_next;
    logic                                  reply_reg, reply_next;
    logic                                  stack_reg, stack_next;
    logic [7:0]                            err_reg, err_next;
    logic [NUM_DENOM-1:0][COUNT_WIDTH-1:0] cnt_reg, cnt_next;

    frame_list_t lst;
    logic [7:0]  tick_inc;
    logic [7:0]  win_sum;
    logic [7:0]  b1, b2, b3;
    logic        bill_hit;
    logic [1:0]  bill_idx;
    logic        sent;
    logic [NUM_DENOM-1:0][COUNT_WIDTH+COUNT_OUT_W-1:0] cnt_ext;

    function automatic frame_list_t push(frame_list_t l, kind_t k,
                                         logic [7:0] a, logic [7:0] b, logic [7:0] c);
        frame_list_t r;
        r = l;
        if (l.n < RES_CNT_W'(MAX_RES))
        begin
            r.f[l.n] = '{kind: k, b1: a, b2: b, b3: c};
            r.n      = l.n + 1'b1;
        end
        return r;
    endfunction

    // host reaction to a status code while auto mode runs
    function automatic frame_list_t stat_react(frame_list_t l, logic en,
                                               logic [7:0] e, logic [7:0] s);
        frame_list_t r;
        r = l;
        if (en)
        begin
            if (s == ST_ESCROW)
            begin
                r = push(r, KIND_SEND, CH_UG, CH_UB, CH_Q);
            end
            else if (s == ST_INIT || s == ST_INHIBITED)
            begin
                r = push(r, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
            end
            else if (s == ST_FAULT)
            begin
                if (e == 8'd0)
                begin
                    r = push(r, KIND_SEND, CH_UG, CH_UB, CH_Q);
                end
                r = push(r, KIND_SEND, CH_UG, CH_UE, CH_Q);
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] err_after(logic en, logic [7:0] e, logic [7:0] s);
        logic [7:0] r;
        r = e;
        if (en && (s == ST_ESCROW || s == ST_INIT || s == ST_INHIBITED))
        begin
            r = 8'd0;
        end
        return r;
    endfunction

    always_comb
    begin
        lst        = '0;
        win_next   = win_reg;
        auto_next  = auto_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        reply_next = reply_reg;
        stack_next = stack_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        tick_inc   = tick_reg + 8'd1;
        b1         = win_reg[1];
        b2         = win_reg[2];
        b3         = win_reg[3];
        win_sum    = b1 + b2 + b3;
        bill_hit   = 1'b1;
        bill_idx   = 2'd0;
        sent       = 1'b0;

        unique case (b3)
            BILL_1000:  bill_idx = 2'd0;
            BILL_5000:  bill_idx = 2'd1;
            BILL_10000: bill_idx = 2'd2;
            BILL_50000: bill_idx = 2'd3;
            default:    bill_hit = 1'b0;
        endcase

        if (step_en)
        begin
            unique case (step_item.mode)
                MODE_BYTE:
                begin
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = step_item.rx_byte;
                    if (win_reg[0] == CH_DOLLAR && step_item.rx_byte == win_sum)
                    begin
                        lst        = push(lst, KIND_REPORT, b1, b2, b3);
                        reply_next = 1'b1;
                        priority if (b1 == CH_LG && b2 == CH_LB)
                        begin
                            // bill frame
                            if (phase_reg == PH_16 && auto_reg)
                            begin
                                lst        = push(lst, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
                                phase_next = PH_10;
                            end
                            if (auto_reg)
                            begin
                                if (bill_hit && cnt_next[bill_idx] != '1)
                                begin
                                    cnt_next[bill_idx] = cnt_next[bill_idx] + 1'b1;
                                end
                                lst = push(lst, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
                            end
                        end
                        else if (b1 == CH_LG && b2 == CH_LC)
                        begin
                            // config frame
                            stack_next = b3[CFG_STACK_BIT];
                            if (auto_reg)
                            begin
                                lst        = push(lst, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
                                phase_next = b3[CFG_NOPOLL_BIT] ? PH_IDLE : PH_10;
                            end
                        end
                        else if (b1 == CH_LG && b2 == CH_LA)
                        begin
                            // status frame
                            lst      = stat_react(lst, auto_reg, err_next, b3);
                            err_next = err_after(auto_reg, err_next, b3);
                            if (phase_reg != PH_IDLE)
                            begin
                                if (phase_reg == PH_12)
                                begin
                                    if (b3 == ST_RESET || b3 == ST_INIT)
                                    begin
                                        lst = push(lst, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
                                        phase_next = PH_11;
                                    end
                                    else if (b3 == ST_STACKING)
                                    begin
                                        if (!stack_reg)
                                        begin
                                            lst = push(lst, KIND_SEND, CH_US, CH_UA, ARG_STACK);
                                            phase_next = PH_14;
                                        end
                                    end
                                    else
                                    begin
                                        phase_next = PH_11;
                                    end
                                end
                                else if (phase_reg == PH_14)
                                begin
                                    if (b3 == ST_STACKING && !stack_reg)
                                    begin
                                        lst = push(lst, KIND_SEND, CH_US, CH_UA, ARG_STACK);
                                    end
                                end
                                else if (phase_reg == PH_16)
                                begin
                                    if (b3 != ST_ESCROW)
                                    begin
                                        phase_next = PH_15;
                                    end
                                end
                            end
                            else
                            begin
                                // idle: the status reaction runs a second time
                                lst      = stat_react(lst, auto_reg, err_next, b3);
                                err_next = err_after(auto_reg, err_next, b3);
                            end
                        end
                        else if (b1 == CH_LG && b2 == CH_LE)
                        begin
                            err_next = b3;
                        end
                        else if (b1 == CH_UE && b2 == CH_US)
                        begin
                            lst      = push(lst, KIND_SEND, CH_LE, CH_LS, b3);
                            lst      = stat_react(lst, auto_reg, err_next, b3);
                            err_next = err_after(auto_reg, err_next, b3);
                        end
                        else if (b1 == CH_UO && b2 == CH_UK)
                        begin
                            if (auto_reg)
                            begin
                                if (phase_reg == PH_10)
                                begin
                                    phase_next = PH_11;
                                end
                                else if (phase_reg == PH_14)
                                begin
                                    phase_next = PH_15;
                                end
                            end
                        end
                        else if (b1 == CH_UN && b2 == CH_UG)
                        begin
                            if (b3 == CH_LC)
                            begin
                                lst = push(lst, KIND_SEND, CH_UG, CH_UC, CH_Q);
                            end
                            else
                            begin
                                lst = push(lst, KIND_SEND, CH_UG, CH_UA, CH_Q);
                            end
                        end
                    end
                end
                MODE_TICK:
                begin
                    unique case (phase_reg)
                        PH_10:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc > TICK_RESEND)
                            begin
                                lst = push(lst, KIND_SEND, CH_US, CH_UA, ARG_ENABLE);
                            end
                        end
                        PH_11:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc > TICK_POLL)
                            begin
                                lst        = push(lst, KIND_SEND, CH_UG, CH_UA, CH_Q);
                                phase_next = PH_12;
                            end
                        end
                        PH_12:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc > TICK_MIN_WAIT &&
                                (reply_reg || tick_inc > TICK_MAX_WAIT))
                            begin
                                phase_next = PH_11;
                            end
                        end
                        PH_15:
                        begin
                            tick_next = tick_inc;
                            if (tick_inc > TICK_POLL)
                            begin
                                lst        = push(lst, KIND_SEND, CH_UG, CH_UA, CH_Q);
                                phase_next = PH_16;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_HOST:
                begin
                    lst = push(lst, KIND_SEND, step_item.cmd_byte, step_item.sub_byte,
                               step_item.arg_byte);
                end
                MODE_AUTO_ON:
                begin
                    if (!auto_reg)
                    begin
                        auto_next = 1'b1;
                        cnt_next  = '0;
                        lst       = push(lst, KIND_SEND, CH_UG, CH_UC, CH_Q);
                    end
                end
                MODE_AUTO_OFF:
                begin
                    auto_next  = 1'b0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end

        // any transmitted frame restarts the reply timeout
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (RES_CNT_W'(i) < lst.n && lst.f[i].kind == KIND_SEND)
            begin
                sent = 1'b1;
            end
        end
        if (sent)
        begin
            tick_next  = 8'd0;
            reply_next = 1'b0;
        end

        for (int i = 0; i < NUM_DENOM; i++)
        begin
            cnt_ext[i]         = {COUNT_OUT_W'(0), cnt_next[i]};
            step_res.counts[i] = cnt_ext[i][COUNT_OUT_W-1:0];
        end
        step_res.frames = lst;
        step_res.phase  = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            auto_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            tick_reg  <= 8'd0;
            reply_reg <= 1'b0;
            stack_reg <= 1'b0;
            err_reg   <= 8'd0;
            cnt_reg   <= '0;
        end
        else if (step_en)
        begin
            win_reg   <= win_next;
            auto_reg  <= auto_next;
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            reply_reg <= reply_next;
            stack_reg <= stack_next;
            err_reg   <= err_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_send_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && sent |=> tick_reg == 8'd0 && !reply_reg)
        else $error("transmitted frame did not clear the reply timer");

    a_auto_off_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && step_item.mode == MODE_AUTO_OFF |=> phase_reg == PH_IDLE && !auto_reg)
        else $error("auto off did not return the sequencer to idle");

    a_no_phase_13: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_13)
        else $error("sequencer entered an unused phase");

endmodule

`default_nettype wire

### hw/rtl/bap_outq.sv
`default_nettype none

module bap_outq
    import bap_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  step_t step,
    output logic  can_load,
    bap_stream_if.source result
);

    logic [RES_CNT_W-1:0]                  left_reg, left_next;
    frame_t [MAX_RES-1:0]                  frm_reg, frm_next;
    logic [NUM_DENOM-1:0][COUNT_OUT_W-1:0] cnt_reg, cnt_next;
    phase_t                                ph_reg, ph_next;
    logic                                  pop;

    assign pop      = result.valid && result.ready;
    assign can_load = (left_reg == '0) ||
                      (left_reg == RES_CNT_W'(1) && result.ready);

    always_comb
    begin
        left_next = left_reg;
        frm_next  = frm_reg;
        cnt_next  = cnt_reg;
        ph_next   = ph_reg;
        if (load)
        begin
            left_next = step.frames.n;
            frm_next  = step.frames.f;
            cnt_next  = step.counts;
            ph_next   = step.phase;
        end
        else if (pop)
        begin
            left_next = left_reg - 1'b1;
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                frm_next[i] = frm_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frm_reg <= frm_next;
        cnt_reg <= cnt_next;
        ph_reg  <= ph_next;
    end

    always_comb
    begin
        result.valid            = (left_reg != '0);
        result.data.kind        = frm_reg[0].kind;
        result.data.first_byte  = frm_reg[0].b1;
        result.data.second_byte = frm_reg[0].b2;
        result.data.third_byte  = frm_reg[0].b3;
        result.data.sum_byte    = frm_reg[0].b1 + frm_reg[0].b2 + frm_reg[0].b3;
        result.data.count_1000  = cnt_reg[0];
        result.data.count_5000  = cnt_reg[1];
        result.data.count_10000 = cnt_reg[2];
        result.data.count_50000 = cnt_reg[3];
        result.data.auto_state  = ph_reg;
        result.data.last        = (left_reg == RES_CNT_W'(1));
    end

    a_left_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= RES_CNT_W'(MAX_RES))
        else $error("result list holds more than its capacity");

    a_stall_holds_list: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg != '0 && !result.ready |=> $stable(left_reg) && $stable(frm_reg[0]))
        else $error("result list changed while the head was stalled");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> left_reg == '0 || (left_reg == RES_CNT_W'(1) && pop))
        else $error("result list overwritten before it drained");

endmodule

`default_nettype wire

### tb/bap_frame_checker.sv
`timescale 1ns / 100ps

module bap_frame_checker
    import bap_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item_data,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result_data,
    output int      fail_count,
    output int      pending,
    output int      items_seen,
    output int      results_seen,
    output int      reports_seen
);

    // mirror of the protocol engine state
    logic [7:0]             rx_win [4];
    logic                   auto_on;
    phase_t                 ph;
    logic [7:0]             ticks;
    logic                   got_reply;
    logic                   stack_on;
    logic [7:0]             err_code;
    logic [COUNT_WIDTH-1:0] bills [NUM_DENOM];

    frame_t  step_frames[$];
    result_t due_results[$];

    int n_fail;
    int n_items;
    int n_results;
    int n_reports;

    task automatic queue_frame(kind_t k, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        frame_t fr;
        fr.kind = k;
        fr.b1   = a;
        fr.b2   = b;
        fr.b3   = c;
        if (step_frames.size() < MAX_RES)
            step_frames.push_back(fr);
    endtask

    // every transmitted frame restarts the tick count and the reply flag
    task automatic send_frame(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        queue_frame(KIND_SEND, a, b, c);
        ticks     = 8'd0;
        got_reply = 1'b0;
    endtask

    task automatic react_status(logic [7:0] s);
        if (auto_on)
        begin
            if (s == ST_ESCROW)
            begin
                send_frame(CH_UG, CH_UB, CH_Q);
                err_code = 8'd0;
            end
            else if (s == ST_INIT || s == ST_INHIBITED)
            begin
                send_frame(CH_US, CH_UA, ARG_ENABLE);
                err_code = 8'd0;
            end
            else if (s == ST_FAULT)
            begin
                if (err_code == 8'd0)
                    send_frame(CH_UG, CH_UB, CH_Q);
                send_frame(CH_UG, CH_UE, CH_Q);
            end
        end
    endtask

    task automatic count_bill(logic [7:0] code);
        int idx;
        idx = -1;
        if (code == BILL_1000)
            idx = 0;
        else if (code == BILL_5000)
            idx = 1;
        else if (code == BILL_10000)
            idx = 2;
        else if (code == BILL_50000)
            idx = 3;
        if (idx >= 0 && bills[idx] != '1)
            bills[idx] = bills[idx] + 1'b1;
    endtask

    task automatic interpret_frame(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
        got_reply = 1'b1;
        if (b1 == CH_LG && b2 == CH_LB)
        begin
            if (ph == PH_16 && auto_on)
            begin
                send_frame(CH_US, CH_UA, ARG_ENABLE);
                ph = PH_10;
            end
            if (auto_on)
            begin
                count_bill(b3);
                send_frame(CH_US, CH_UA, ARG_ENABLE);
            end
        end
        else if (b1 == CH_LG && b2 == CH_LC)
        begin
            stack_on = b3[CFG_STACK_BIT];
            if (auto_on)
            begin
                send_frame(CH_US, CH_UA, ARG_ENABLE);
                ph = b3[CFG_NOPOLL_BIT] ? PH_IDLE : PH_10;
            end
        end
        else if (b1 == CH_LG && b2 == CH_LA)
        begin
            react_status(b3);
            if (ph != PH_IDLE)
            begin
                case (ph)
                    PH_12:
                    begin
                        if (b3 == ST_RESET || b3 == ST_INIT)
                        begin
                            send_frame(CH_US, CH_UA, ARG_ENABLE);
                            ph = PH_11;
                        end
                        else if (b3 == ST_STACKING)
                        begin
                            if (!stack_on)
                            begin
                                send_frame(CH_US, CH_UA, ARG_STACK);
                                ph = PH_14;
                            end
                        end
                        else
                            ph = PH_11;
                    end
                    PH_14:
                    begin
                        if (b3 == ST_STACKING && !stack_on)
                            send_frame(CH_US, CH_UA, ARG_STACK);
                    end
                    PH_16:
                    begin
                        if (b3 != ST_ESCROW)
                            ph = PH_15;
                    end
                    default: ;
                endcase
            end
            else
                react_status(b3);   // idle: the reaction runs a second time
        end
        else if (b1 == CH_LG && b2 == CH_LE)
            err_code = b3;
        else if (b1 == CH_UE && b2 == CH_US)
        begin
            send_frame(CH_LE, CH_LS, b3);
            react_status(b3);
        end
        else if (b1 == CH_UO && b2 == CH_UK)
        begin
            if (auto_on)
            begin
                if (ph == PH_10)
                    ph = PH_11;
                else if (ph == PH_14)
                    ph = PH_15;
            end
        end
        else if (b1 == CH_UN && b2 == CH_UG)
        begin
            if (b3 == CH_LC)
                send_frame(CH_UG, CH_UC, CH_Q);
            else
                send_frame(CH_UG, CH_UA, CH_Q);
        end
    endtask

    task automatic shift_byte(logic [7:0] b);
        logic [7:0] f0;
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] f3;
        logic [7:0] s;
        f0 = rx_win[0];
        f1 = rx_win[1];
        f2 = rx_win[2];
        f3 = rx_win[3];
        rx_win[0] = f1;
        rx_win[1] = f2;
        rx_win[2] = f3;
        rx_win[3] = b;
        s = f1 + f2 + f3;
        if (f0 == CH_DOLLAR && b == s)
        begin
            queue_frame(KIND_REPORT, f1, f2, f3);
            interpret_frame(f1, f2, f3);
        end
    endtask

    task automatic run_tick();
        case (ph)
            PH_10:
            begin
                ticks = ticks + 8'd1;
                if (ticks > TICK_RESEND)
                    send_frame(CH_US, CH_UA, ARG_ENABLE);
            end
            PH_11:
            begin
                ticks = ticks + 8'd1;
                if (ticks > TICK_POLL)
                begin
                    send_frame(CH_UG, CH_UA, CH_Q);
                    ph = PH_12;
                end
            end
            PH_12:
            begin
                ticks = ticks + 8'd1;
                if (ticks > TICK_MIN_WAIT && (got_reply || ticks > TICK_MAX_WAIT))
                    ph = PH_11;
            end
            PH_15:
            begin
                ticks = ticks + 8'd1;
                if (ticks > TICK_POLL)
                begin
                    send_frame(CH_UG, CH_UA, CH_Q);
                    ph = PH_16;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_frames(item_t it);
        result_t r;
        step_frames.delete();
        case (it.mode)
            MODE_BYTE:     shift_byte(it.rx_byte);
            MODE_TICK:     run_tick();
            MODE_HOST:     send_frame(it.cmd_byte, it.sub_byte, it.arg_byte);
            MODE_AUTO_ON:
            begin
                if (!auto_on)
                begin
                    auto_on = 1'b1;
                    foreach (bills[i])
                        bills[i] = '0;
                    send_frame(CH_UG, CH_UC, CH_Q);
                end
            end
            MODE_AUTO_OFF:
            begin
                auto_on = 1'b0;
                ph      = PH_IDLE;
            end
            default: ;
        endcase
        // counters and phase are reported as they stand after the whole item
        foreach (step_frames[k])
        begin
            r.kind        = step_frames[k].kind;
            r.first_byte  = step_frames[k].b1;
            r.second_byte = step_frames[k].b2;
            r.third_byte  = step_frames[k].b3;
            r.sum_byte    = step_frames[k].b1 + step_frames[k].b2 + step_frames[k].b3;
            r.count_1000  = 16'(bills[0]);
            r.count_5000  = 16'(bills[1]);
            r.count_10000 = 16'(bills[2]);
            r.count_50000 = 16'(bills[3]);
            r.auto_state  = ph;
            r.last        = (k == step_frames.size() - 1);
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            n_fail++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            foreach (rx_win[i])
                rx_win[i] = 8'd0;
            foreach (bills[i])
                bills[i] = '0;
            auto_on   = 1'b0;
            ph        = PH_IDLE;
            ticks     = 8'd0;
            got_reply = 1'b0;
            stack_on  = 1'b0;
            err_code  = 8'd0;
            due_results.delete();
            n_fail    = 0;
            n_items   = 0;
            n_results = 0;
            n_reports = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_frames(item_data);
                n_items++;
            end
            if (result_valid && result_ready)
            begin
                got = result_data;
                n_results++;
                if (got.kind == KIND_REPORT)
                    n_reports++;
                if (due_results.size() == 0)
                begin
                    $error("result transaction with nothing expected: %0h", got);
                    n_fail++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("first_byte", want.first_byte, got.first_byte);
                    check_field("second_byte", want.second_byte, got.second_byte);
                    check_field("third_byte", want.third_byte, got.third_byte);
                    check_field("sum_byte", want.sum_byte, got.sum_byte);
                    check_field("count_1000", want.count_1000, got.count_1000);
                    check_field("count_5000", want.count_5000, got.count_5000);
                    check_field("count_10000", want.count_10000, got.count_10000);
                    check_field("count_50000", want.count_50000, got.count_50000);
                    check_field("auto_state", want.auto_state, got.auto_state);
                    check_field("last", want.last, got.last);
                end
            end
        end
        fail_count   <= n_fail;
        pending      <= due_results.size();
        items_seen   <= n_items;
        results_seen <= n_results;
        reports_seen <= n_reports;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import bap_pkg::*;

    // narrow internal counters; the reported counts are zero extended to 16 bits
    localparam int COUNT_W      = 8;
    localparam int BILL_FRAMES  = 2;
    localparam int RANDOM_ITEMS = 70;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 6;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 50000;

    logic clk;
    logic rst_n;

    bap_stream_if #(.data_t(item_t))   item_ch ();
    bap_stream_if #(.data_t(result_t)) result_ch ();

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int reports_seen;

    // sender idling state
    int items_sent;
    int send_calm_left;
    bit send_calm;

    int cycles;

    bill_acceptor_host_protocol #(
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    bap_frame_checker #(
        .COUNT_WIDTH (COUNT_W)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .item_data    (item_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data),
        .fail_count   (fail_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .results_seen (results_seen),
        .reports_seen (reports_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset, asserted at the start only
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** bill_acceptor_host_protocol: FAILED **");
        $finish;
    end

    // every item carries random bytes in the fields its mode does not use
    function automatic item_t rand_item(logic [2:0] m);
        item_t it;
        it.mode     = m;
        it.rx_byte  = 8'($urandom);
        it.cmd_byte = 8'($urandom);
        it.sub_byte = 8'($urandom);
        it.arg_byte = 8'($urandom);
        return it;
    endfunction

    // offer one item transaction and return at the edge it is taken;
    // valid stays high across back-to-back items
    task automatic drive_item(item_t it);
        int gap;
        if (send_calm_left == 0)
        begin
            send_calm      = ($urandom_range(0, 3) == 0);
            send_calm_left = $urandom_range(10, 40);
        end
        send_calm_left--;
        gap = send_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put_mode(logic [2:0] m);
        drive_item(rand_item(m));
    endtask

    task automatic put_byte(logic [7:0] b);
        item_t it;
        it         = rand_item(MODE_BYTE);
        it.rx_byte = b;
        drive_item(it);
    endtask

    task automatic put_host(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        item_t it;
        it          = rand_item(MODE_HOST);
        it.cmd_byte = a;
        it.sub_byte = b;
        it.arg_byte = c;
        drive_item(it);
    endtask

    // well-formed acceptor frame: '$', payload, 8-bit sum
    task automatic put_frame(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
        logic [7:0] s;
        s = b1 + b2 + b3;
        put_byte(CH_DOLLAR);
        put_byte(b1);
        put_byte(b2);
        put_byte(b3);
        put_byte(s);
    endtask

    // status codes the sequencer reacts to, plus arbitrary ones
    function automatic logic [7:0] pick_status();
        case ($urandom_range(0, 7))
            0:       return ST_RESET;
            1:       return ST_INIT;
            2:       return ST_STACKING;
            3:       return ST_ESCROW;
            4:       return ST_FAULT;
            5:       return ST_INHIBITED;
            default: return 8'($urandom);
        endcase
    endfunction

    // receiver: random stalls, calm stretches, and one long hold-off that
    // backs the block up into its input
    initial
    begin
        int  gap;
        int  calm_left;
        bit  calm;
        bit  held;
        calm_left = 0;
        calm      = 1'b0;
        held      = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            if (calm_left == 0)
            begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(10, 40);
            end
            calm_left--;
            gap = calm ? 0 : $urandom_range(0, 12);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int         rand_start;
        int         sel;
        int         len;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] s;

        items_sent     = 0;
        send_calm_left = 0;
        send_calm      = 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;

        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // --- directed part ---
        put_host(8'h00, 8'h00, 8'h00);          // host frame, all zero
        put_host(8'hFF, 8'hFF, 8'hFF);          // host frame, all ones
        put_mode(3'd7);                         // unknown mode, ignored
        put_mode(MODE_AUTO_OFF);                // auto off while already off
        put_mode(MODE_TICK);                    // tick while idle does nothing
        put_byte(8'hFF);                        // stray byte, only shifts the window
        put_mode(MODE_AUTO_ON);                 // auto on asks for config
        put_mode(MODE_AUTO_ON);                 // auto on again is ignored
        put_frame(CH_LG, CH_LC, 8'h30);         // config: stacking on, no polling
        put_frame(CH_LG, CH_LA, ST_ESCROW);     // status while idle: reaction twice
        put_frame(CH_LG, CH_LC, 8'h00);         // config: polling, stacking off
        put_mode(MODE_TICK);
        put_frame(CH_UO, CH_UK, 8'h00);         // ack moves the poll phase on

        // --- restart auto mode and count a few bills ---
        put_mode(MODE_AUTO_OFF);
        put_mode(MODE_AUTO_ON);
        repeat (BILL_FRAMES)
            put_frame(CH_LG, CH_LB, BILL_5000);

        // --- random part: mostly well-formed frames, ticks, commands ---
        rand_start = items_sent;
        while (items_sent < rand_start + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                case ($urandom_range(0, 7))
                    0, 1:    put_frame(CH_LG, CH_LA, pick_status());
                    2:
                    begin
                        case ($urandom_range(0, 4))
                            0:       b3 = BILL_1000;
                            1:       b3 = BILL_5000;
                            2:       b3 = BILL_10000;
                            3:       b3 = BILL_50000;
                            default: b3 = 8'($urandom);
                        endcase
                        put_frame(CH_LG, CH_LB, b3);
                    end
                    3:
                    begin
                        // mostly keep polling enabled
                        b3 = 8'($urandom);
                        if ($urandom_range(0, 4) != 0)
                            b3[CFG_NOPOLL_BIT] = 1'b0;
                        put_frame(CH_LG, CH_LC, b3);
                    end
                    4:       put_frame(CH_LG, CH_LE,
                                       ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
                    5:       put_frame(CH_UE, CH_US, pick_status());
                    6:       put_frame(CH_UO, CH_UK, 8'($urandom));
                    default: put_frame(CH_UN, CH_UG,
                                       ($urandom_range(0, 1) == 0) ? CH_LC : 8'($urandom));
                endcase
            end
            else if (sel < 65)
            begin
                // short bursts, sometimes long enough to hit the wait limits
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 22)
                                                   : $urandom_range(1, 4);
                repeat (len)
                    put_mode(MODE_TICK);
            end
            else if (sel < 72)
                put_host(8'($urandom), 8'($urandom), 8'($urandom));
            else if (sel < 78)
                put_mode(MODE_AUTO_ON);
            else if (sel < 81)
                put_mode(MODE_AUTO_OFF);
            else if (sel < 89)
                put_byte(8'($urandom));
            else if (sel < 97)
            begin
                // broken frame: bad check byte or cut short
                b1 = 8'($urandom);
                b2 = 8'($urandom);
                b3 = 8'($urandom);
                s  = b1 + b2 + b3;
                put_byte(CH_DOLLAR);
                put_byte(b1);
                put_byte(b2);
                if ($urandom_range(0, 1) == 0)
                begin
                    put_byte(b3);
                    put_byte(s ^ (8'd1 << $urandom_range(0, 7)));
                end
            end
            else
                put_mode(3'($urandom_range(5, 7)));
        end

        item_ch.valid <= 1'b0;

        // let the checker see the last item, drain outstanding results,
        // then give the block time for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d item transactions, %0d result transactions (%0d frame reports)",
                 items_seen, results_seen, reports_seen);
        $display("run: directed cases, bill counting, random frame traffic, %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("** bill_acceptor_host_protocol: PASSED **");
        else
            $display("** bill_acceptor_host_protocol: FAILED **");
        $finish;
    end

endmodule
